// ===== rtl/rhr_pkg.sv =====
package rhr_pkg;

  localparam int DEPTH_DEF = 256;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] frame_id;
  } in_t;

  typedef struct packed {
    logic [7:0] rec_x;
    logic [7:0] rec_y;
    logic [7:0] rec_frame;
    logic       rec_valid;
    logic [8:0] fill_count;
    logic       overwrote;
  } out_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] frame;
  } rec_t;

endpackage

// ===== rtl/rewind_history_ring_core.sv =====
// Rewind history ring: a circular stack of (x, y, frame) records.
//
// Commands arrive on start/in_item and are taken at any clock edge where
// start is high and busy is low. busy never rises: the single-port record
// memory serves a push write or a pop read in the cycle a command is taken,
// so one command can be taken every cycle.
//
// opcode push stores a record at the head; once DEPTH records are held the
// oldest is overwritten and overwrote is flagged. pop returns the newest
// record and steps the head back; on an empty history it returns
// rec_valid = 0 and changes nothing. clear empties the history without
// touching memory contents. The fourth code only reports the fill count.
//
// Every command gives exactly one result on out_item, flagged by out_valid
// for one cycle, in the cycle after the command was taken (one result per
// cycle). The receiver cannot stall; results must be taken as they appear.
// Reset empties the history at once (no clearing pass).
module rewind_history_ring_core #(
  parameter int DEPTH = rhr_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  rhr_pkg::in_t in_item,
  output logic         out_valid,
  output rhr_pkg::out_t out_item
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              accept;
  logic              do_push, do_pop;
  logic              full;
  logic [ADDR_W-1:0] head_inc, head_dec;

  rhr_pkg::rec_t     mem [DEPTH];
  rhr_pkg::rec_t     rd_q_r;
  rhr_pkg::rec_t     wr_data;

  logic              out_valid_r;
  logic              rec_valid_r;
  logic              over_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W+8:0]  fill_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == FULL_CNT);

  assign do_push = accept && (in_item.opcode == rhr_pkg::OP_PUSH);
  assign do_pop  = accept && (in_item.opcode == rhr_pkg::OP_POP) && (count_r != '0);

  assign head_inc = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_ADDR : head_r - 1'b1;

  assign wr_data = '{x: in_item.pos_x, y: in_item.pos_y, frame: in_item.frame_id};

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (accept) begin
      case (in_item.opcode)
        rhr_pkg::OP_PUSH: begin
          head_nxt = head_inc;
          if (!full) begin
            count_nxt = count_r + 1'b1;
          end
        end
        rhr_pkg::OP_POP: begin
          if (count_r != '0) begin
            head_nxt  = head_dec;
            count_nxt = count_r - 1'b1;
          end
        end
        rhr_pkg::OP_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result side fields; rec fields come straight from the memory read register
  always_ff @(posedge clk) begin
    if (accept) begin
      rec_valid_r <= do_pop;
      over_r      <= do_push && full;
      fill_r      <= count_nxt;
    end
  end

  // record memory: push writes the head, pop reads one behind it
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[head_r] <= wr_data;
    end
    if (do_pop) begin
      rd_q_r <= mem[head_dec];
    end
  end

  assign fill_wide = {9'b0, fill_r};

  assign out_valid           = out_valid_r;
  assign out_item.rec_x      = rec_valid_r ? rd_q_r.x : 8'd0;
  assign out_item.rec_y      = rec_valid_r ? rd_q_r.y : 8'd0;
  assign out_item.rec_frame  = rec_valid_r ? rd_q_r.frame : 8'd0;
  assign out_item.rec_valid  = rec_valid_r;
  assign out_item.fill_count = fill_wide[8:0];
  assign out_item.overwrote  = over_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("history count above depth");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("command taken without a result");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> out_item.rec_valid && (count_r == $past(count_r) - 1'b1))
    else $error("pop on nonempty history did not return a record");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && full) |=> out_item.overwrote && (count_r == FULL_CNT))
    else $error("push on full history lost its limit");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.opcode == rhr_pkg::OP_POP) && (count_r == '0))
      |=> !out_item.rec_valid && $stable(head_r))
    else $error("pop on empty history changed state");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int HIST_DEPTH = rhr_pkg::DEPTH_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rhr_pkg::in_t in_item = '0;
  logic out_valid;
  rhr_pkg::out_t out_item;

  rewind_history_ring_core #(
    .DEPTH(HIST_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the history ring
  rhr_pkg::rec_t hist_mem [HIST_DEPTH];
  int   hist_head;
  int   hist_count;
  rhr_pkg::out_t pending_recs[$];

  int errors = 0;
  int sent = 0;
  int n_push = 0, n_pop_hit = 0, n_pop_empty = 0, n_overwrite = 0, n_clear = 0, n_nop = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic track_history(input rhr_pkg::in_t cmd, output rhr_pkg::out_t res);
    res = '0;
    case (cmd.opcode)
      rhr_pkg::OP_PUSH: begin
        hist_mem[hist_head] = '{x: cmd.pos_x, y: cmd.pos_y, frame: cmd.frame_id};
        hist_head = (hist_head + 1) % HIST_DEPTH;
        n_push++;
        if (hist_count >= HIST_DEPTH) begin
          hist_count = HIST_DEPTH;
          res.overwrote = 1'b1;
          n_overwrite++;
        end else begin
          hist_count++;
        end
      end
      rhr_pkg::OP_POP: begin
        if (hist_count != 0) begin
          hist_head = (hist_head + HIST_DEPTH - 1) % HIST_DEPTH;
          hist_count--;
          res.rec_x = hist_mem[hist_head].x;
          res.rec_y = hist_mem[hist_head].y;
          res.rec_frame = hist_mem[hist_head].frame;
          res.rec_valid = 1'b1;
          n_pop_hit++;
        end else begin
          n_pop_empty++;
        end
      end
      rhr_pkg::OP_CLEAR: begin
        hist_head = 0;
        hist_count = 0;
        n_clear++;
      end
      default: n_nop++;
    endcase
    res.fill_count = hist_count[8:0];
  endtask

  // one command transfer; bursts of back-to-back commands, separated by idle gaps while gaps_on is set
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                          input logic [7:0] f);
    rhr_pkg::in_t  cmd;
    rhr_pkg::out_t res;
    int   gap;
    cmd = '{opcode: op, pos_x: x, pos_y: y, frame_id: f};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 5);
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    track_history(cmd, res);
    pending_recs.push_back(res);
    sent++;
  endtask

  task automatic send_rand(input logic [1:0] op);
    send_cmd(op, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    send_cmd(rhr_pkg::OP_POP, 8'hFF, 8'hFF, 8'hFF);   // pop on empty
    send_cmd(rhr_pkg::OP_NOP, 8'hFF, 8'h00, 8'hFF);
    send_cmd(rhr_pkg::OP_PUSH, 8'h00, 8'h00, 8'h00);
    send_cmd(rhr_pkg::OP_PUSH, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(rhr_pkg::OP_PUSH, 8'hAA, 8'h55, 8'h0F);
    send_cmd(rhr_pkg::OP_NOP, 8'h12, 8'h34, 8'h56);
    send_cmd(rhr_pkg::OP_POP, 8'h00, 8'h00, 8'h00);
    send_cmd(rhr_pkg::OP_POP, 8'h00, 8'h00, 8'h00);
    send_cmd(rhr_pkg::OP_POP, 8'h00, 8'h00, 8'h00);
    send_cmd(rhr_pkg::OP_POP, 8'h00, 8'h00, 8'h00);   // empty again
    send_cmd(rhr_pkg::OP_PUSH, 8'h01, 8'h02, 8'h03);
    send_cmd(rhr_pkg::OP_PUSH, 8'h80, 8'h40, 8'h20);
    send_cmd(rhr_pkg::OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(rhr_pkg::OP_POP, 8'h00, 8'h00, 8'h00);   // nothing left after clear
    send_cmd(rhr_pkg::OP_NOP, 8'h00, 8'h00, 8'h00);
    send_cmd(rhr_pkg::OP_PUSH, 8'h55, 8'hAA, 8'hF0);
    send_cmd(rhr_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00);
    send_cmd(rhr_pkg::OP_PUSH, 8'h7F, 8'h80, 8'hFE);
    send_cmd(rhr_pkg::OP_POP, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(rhr_pkg::OP_POP, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // fill past capacity so the oldest records get overwritten, then drain
  task automatic test_overflow();
    int extra;
    extra = $urandom_range(5, 40);
    gaps_on = 1'b0;
    send_rand(rhr_pkg::OP_CLEAR);
    repeat (HIST_DEPTH + extra) send_rand(rhr_pkg::OP_PUSH);
    send_rand(rhr_pkg::OP_NOP);
    gaps_on = 1'b1;
    repeat (HIST_DEPTH + 3) send_rand(rhr_pkg::OP_POP);
    send_rand(rhr_pkg::OP_NOP);
  endtask

  task automatic test_random(input int target);
    int r, len, sel;
    logic [1:0] op;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(1, 40);
      gaps_on = ($urandom_range(0, 9) != 0);
      if (r < 45) begin
        // push run with a little noise
        repeat (len) begin
          sel = $urandom_range(0, 99);
          op = (sel < 85) ? rhr_pkg::OP_PUSH : (sel < 93) ? rhr_pkg::OP_NOP : rhr_pkg::OP_POP;
          send_rand(op);
        end
      end else if (r < 85) begin
        repeat (len) begin
          sel = $urandom_range(0, 99);
          op = (sel < 85) ? rhr_pkg::OP_POP : (sel < 93) ? rhr_pkg::OP_NOP : rhr_pkg::OP_PUSH;
          send_rand(op);
        end
      end else if (r < 92) begin
        send_rand(rhr_pkg::OP_CLEAR);
      end else begin
        repeat ($urandom_range(1, 4)) send_rand(rhr_pkg::OP_NOP);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    rhr_pkg::out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_recs.size() == 0) begin
        report_mismatch("unexpected result, fill_count", int'(out_item.fill_count), -1);
      end else begin
        want = pending_recs.pop_front();
        if (out_item.rec_x !== want.rec_x)
          report_mismatch("rec_x", int'(out_item.rec_x), int'(want.rec_x));
        if (out_item.rec_y !== want.rec_y)
          report_mismatch("rec_y", int'(out_item.rec_y), int'(want.rec_y));
        if (out_item.rec_frame !== want.rec_frame)
          report_mismatch("rec_frame", int'(out_item.rec_frame), int'(want.rec_frame));
        if (out_item.rec_valid !== want.rec_valid)
          report_mismatch("rec_valid", int'(out_item.rec_valid), int'(want.rec_valid));
        if (out_item.fill_count !== want.fill_count)
          report_mismatch("fill_count", int'(out_item.fill_count), int'(want.fill_count));
        if (out_item.overwrote !== want.overwrote)
          report_mismatch("overwrote", int'(out_item.overwrote), int'(want.overwrote));
      end
    end
  end

  initial begin
    #400us;
    $display("timeout with %0d results outstanding", pending_recs.size());
    $display("rewind_history_ring_core: mismatch");
    $finish;
  end

  initial begin
    int wait_cycles;
    hist_head = 0;
    hist_count = 0;
    for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_overflow();
    test_random(1850);

    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_recs.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (pending_recs.size() != 0)
      report_mismatch("results never delivered", 0, pending_recs.size());

    $display("%0d commands: %0d pushes (%0d overwrote), %0d pops with data, %0d on empty",
             sent, n_push, n_overwrite, n_pop_hit, n_pop_empty);
    $display("%0d clears, %0d no-ops, %0d mismatches", n_clear, n_nop, errors);
    if (errors == 0) begin
      $display("rewind_history_ring_core: match");
    end else begin
      $display("rewind_history_ring_core: mismatch");
    end
    $finish;
  end

endmodule
